/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

/* hdl/irdl_pkg.sv */
// ----------------------------------------------------------------------------
// irdl_pkg
// Breakpoint tables, reciprocals, widths and register codes of the IR
// distance linearizer.
// ----------------------------------------------------------------------------
package irdl_pkg;

	localparam int NUM_PTS  = 15;
	localparam int NUM_SEG  = NUM_PTS - 1;
	localparam int SEG_W    = $clog2(NUM_SEG);
	localparam int SMP_W    = 12;
	localparam int CM_W     = 10;
	localparam int FRAC     = 8;
	localparam int LIMIT_W  = 7;
	localparam int SPAN_W   = 4;
	localparam int DIFF_W   = SMP_W;
	localparam int NUM_W    = SPAN_W + DIFF_W + FRAC;
	localparam int RSHIFT   = NUM_W;
	localparam int RECIP_W  = 20;
	localparam int PROD_W   = NUM_W + RECIP_W;
	localparam int Q_W      = SPAN_W + FRAC;
	localparam int QD_W     = Q_W + DIFF_W;
	localparam int DIST_W   = CM_W + FRAC + 1;
	localparam int OUT_W    = 15;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [OUT_W-1:0]   DIST_MAX    = {OUT_W{1'b1}};
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(60);
	localparam logic [SPAN_W-1:0]  SPAN_RESET  = SPAN_W'(5);

	localparam logic REG_LIMIT = 1'b0;
	localparam logic REG_SPAN  = 1'b1;

	localparam longint unsigned RSCALE = 64'd1 << RSHIFT;

	localparam logic [SMP_W-1:0] BRK [NUM_PTS] = '{
		12'd4095, 12'd3050, 12'd1980, 12'd1370, 12'd950, 12'd830, 12'd730, 12'd650,
		12'd570, 12'd530, 12'd460, 12'd390, 12'd330, 12'd300, 12'd0
	};

	localparam logic [CM_W-1:0] CM [NUM_PTS] = '{
		10'd0, 10'd10, 10'd15, 10'd20, 10'd25, 10'd30, 10'd35, 10'd40,
		10'd45, 10'd50, 10'd55, 10'd60, 10'd65, 10'd70, 10'd999
	};

	localparam logic [DIFF_W-1:0] SEG_LEN [NUM_SEG] = '{
		BRK[0] - BRK[1],   BRK[1] - BRK[2],   BRK[2] - BRK[3],   BRK[3] - BRK[4],
		BRK[4] - BRK[5],   BRK[5] - BRK[6],   BRK[6] - BRK[7],   BRK[7] - BRK[8],
		BRK[8] - BRK[9],   BRK[9] - BRK[10],  BRK[10] - BRK[11], BRK[11] - BRK[12],
		BRK[12] - BRK[13], BRK[13] - BRK[14]
	};

	// floor(2^RSHIFT / len); quotient estimate is then low by at most one
	localparam logic [RECIP_W-1:0] RECIP [NUM_SEG] = '{
		RECIP_W'(RSCALE / SEG_LEN[0]),  RECIP_W'(RSCALE / SEG_LEN[1]),
		RECIP_W'(RSCALE / SEG_LEN[2]),  RECIP_W'(RSCALE / SEG_LEN[3]),
		RECIP_W'(RSCALE / SEG_LEN[4]),  RECIP_W'(RSCALE / SEG_LEN[5]),
		RECIP_W'(RSCALE / SEG_LEN[6]),  RECIP_W'(RSCALE / SEG_LEN[7]),
		RECIP_W'(RSCALE / SEG_LEN[8]),  RECIP_W'(RSCALE / SEG_LEN[9]),
		RECIP_W'(RSCALE / SEG_LEN[10]), RECIP_W'(RSCALE / SEG_LEN[11]),
		RECIP_W'(RSCALE / SEG_LEN[12]), RECIP_W'(RSCALE / SEG_LEN[13])
	};

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} div_adv_t;

	typedef struct packed {
		logic [SEG_W-1:0] seg;
		logic             found;
		logic             top;
	} seg_info_t;

endpackage

/* hdl/irdl_recip_div.sv */
// ----------------------------------------------------------------------------
// irdl_recip_div
// Three-stage divide of the scaled numerator by the segment length:
// reciprocal multiply, back-multiply, remainder correction.
// ----------------------------------------------------------------------------
module irdl_recip_div (
	input  logic                                clk,
	input  irdl_pkg::div_adv_t                  adv,
	input  logic [irdl_pkg::NUM_W-1:0]          num,
	input  logic [irdl_pkg::SEG_W-1:0]          seg,
	output logic [irdl_pkg::Q_W-1:0]            quot
);

	logic [irdl_pkg::PROD_W-1:0] prod_s3;
	logic [irdl_pkg::NUM_W-1:0]  num_s3;
	logic [irdl_pkg::SEG_W-1:0]  seg_s3;
	logic [irdl_pkg::Q_W-1:0]    q0_s4;
	logic [irdl_pkg::QD_W-1:0]   qd_s4;
	logic [irdl_pkg::NUM_W-1:0]  num_s4;
	logic [irdl_pkg::SEG_W-1:0]  seg_s4;
	logic [irdl_pkg::Q_W-1:0]    quot_s5;
	logic [irdl_pkg::Q_W-1:0]    q0;
	logic [irdl_pkg::NUM_W-1:0]  rem;

	assign q0  = prod_s3[irdl_pkg::RSHIFT +: irdl_pkg::Q_W];
	assign rem = num_s4 - irdl_pkg::NUM_W'(qd_s4);

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			prod_s3 <= irdl_pkg::PROD_W'(num) * irdl_pkg::PROD_W'(irdl_pkg::RECIP[seg]);
			num_s3  <= num;
			seg_s3  <= seg;
		end
		if (adv.s4) begin
			q0_s4  <= q0;
			qd_s4  <= irdl_pkg::QD_W'(q0) * irdl_pkg::QD_W'(irdl_pkg::SEG_LEN[seg_s3]);
			num_s4 <= num_s3;
			seg_s4 <= seg_s3;
		end
		if (adv.s5) begin
			quot_s5 <= q0_s4 + irdl_pkg::Q_W'(rem >= irdl_pkg::NUM_W'(irdl_pkg::SEG_LEN[seg_s4]));
		end
	end

	assign quot = quot_s5;

endmodule

/* hdl/ir_distance_linearizer_core.sv */
// ----------------------------------------------------------------------------
// ir_distance_linearizer_core
// Piecewise-linear conversion of an IR sensor ADC sample to distance.
// ----------------------------------------------------------------------------
// Input channel: sample_valid / sample_stall with a 12-bit sample per beat.
// Output channel: result_valid / result_stall with distance_q8 (cm, 8
// fraction bits, saturated at 32767) and out_of_range (distance above the
// configured limit).
// The APB port holds the limit (address 0) and the segment span (address 4);
// write them only while no beat is in flight.
// Six register stages: segment search, numerator multiply, reciprocal
// multiply, back-multiply, remainder correction, final add and compare.
// A result is presented from the final stage register; one sample per
// cycle is accepted in steady state while result_stall is low.
// A stall on the output holds the last stage; earlier stages keep filling
// bubbles, and sample_stall rises only when all six stages hold data.
// Reset empties the pipeline and restores limit 60 cm and span 5 cm.
// ----------------------------------------------------------------------------
module ir_distance_linearizer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [irdl_pkg::ADDR_W-1:0]         paddr,
	input  logic [irdl_pkg::DATA_W-1:0]         pwdata,
	output logic [irdl_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic [irdl_pkg::SMP_W-1:0]          sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [irdl_pkg::OUT_W-1:0]          distance_q8,
	output logic                                out_of_range
);

	logic [irdl_pkg::LIMIT_W-1:0] limit_q;
	logic [irdl_pkg::SPAN_W-1:0]  span_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;
	irdl_pkg::div_adv_t div_adv;

	irdl_pkg::seg_info_t info_c, info_s1, info_s2, info_s3, info_s4, info_s5;
	logic [irdl_pkg::SMP_W-1:0]  sample_s1;
	logic [irdl_pkg::NUM_W-1:0]  num_s2;
	logic [irdl_pkg::DIFF_W-1:0] diff;
	logic [irdl_pkg::Q_W-1:0]    quot_s5;
	logic [irdl_pkg::DIST_W-1:0] dist_c;
	logic [irdl_pkg::OUT_W-1:0]  dist_s6;
	logic                        oor_s6;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= irdl_pkg::LIMIT_RESET;
			span_q  <= irdl_pkg::SPAN_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				irdl_pkg::REG_LIMIT: limit_q <= pwdata[irdl_pkg::LIMIT_W-1:0];
				irdl_pkg::REG_SPAN:  span_q  <= pwdata[irdl_pkg::SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			irdl_pkg::REG_LIMIT: prdata = irdl_pkg::DATA_W'(limit_q);
			irdl_pkg::REG_SPAN:  prdata = irdl_pkg::DATA_W'(span_q);
			default:             prdata = '0;
		endcase
	end

	// pipeline flow control
	assign adv6 = !v_s6 || !result_stall;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign sample_stall = !adv1;
	assign div_adv = '{s3: adv3, s4: adv4, s5: adv5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= sample_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// stage 1: segment search, lowest matching segment wins
	always_comb begin
		info_c.seg   = '0;
		info_c.found = 1'b0;
		info_c.top   = sample >= irdl_pkg::BRK[0];
		for (int i = irdl_pkg::NUM_SEG - 1; i >= 0; i--) begin
			if (sample < irdl_pkg::BRK[i] && sample >= irdl_pkg::BRK[i+1]) begin
				info_c.seg   = irdl_pkg::SEG_W'(i);
				info_c.found = 1'b1;
			end
		end
	end

	// stage 2: numerator span * (hi - sample) << FRAC
	assign diff = irdl_pkg::BRK[info_s1.seg] - sample_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			info_s1   <= info_c;
			sample_s1 <= sample;
		end
		if (adv2) begin
			info_s2 <= info_s1;
			num_s2  <= (irdl_pkg::NUM_W'(span_q) * irdl_pkg::NUM_W'(diff)) << irdl_pkg::FRAC;
		end
		if (adv3) info_s3 <= info_s2;
		if (adv4) info_s4 <= info_s3;
		if (adv5) info_s5 <= info_s4;
	end

	// stages 3..5
	irdl_recip_div u_div (
		.clk  (clk),
		.adv  (div_adv),
		.num  (num_s2),
		.seg  (info_s2.seg),
		.quot (quot_s5)
	);

	// stage 6: base plus fraction (0 at top), saturate, limit compare
	always_comb begin
		if (info_s5.top)
			dist_c = '0;
		else if (info_s5.found)
			dist_c = (irdl_pkg::DIST_W'(irdl_pkg::CM[info_s5.seg]) << irdl_pkg::FRAC)
				+ irdl_pkg::DIST_W'(quot_s5);
		else
			dist_c = irdl_pkg::DIST_W'(irdl_pkg::CM[irdl_pkg::NUM_PTS-1]) << irdl_pkg::FRAC;
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			dist_s6 <= (dist_c > irdl_pkg::DIST_W'(irdl_pkg::DIST_MAX)) ?
				irdl_pkg::DIST_MAX : dist_c[irdl_pkg::OUT_W-1:0];
			oor_s6  <= dist_c > (irdl_pkg::DIST_W'(limit_q) << irdl_pkg::FRAC);
		end
	end

	assign result_valid = v_s6;
	assign distance_q8  = dist_s6;
	assign out_of_range = oor_s6;

endmodule

/* hdl/irdl_checker.sv */
// ----------------------------------------------------------------------------
// irdl_checker
// Port-level checks of the IR distance linearizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irdl_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_stall,
	input  logic                                result_valid,
	input  logic                                result_stall,
	input  logic [irdl_pkg::OUT_W-1:0]          distance_q8,
	input  logic                                out_of_range
);

	// held result beat stays presented
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid)

	// input only backs up when the output is full and stalled
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, sample_stall, result_valid && result_stall)

	// a flagged distance can never be zero
	`ASSERT_IMPL(a_flag_nonzero, clk, arst_n, result_valid && out_of_range, distance_q8 != '0)

	// above the largest possible limit the flag must be set
	`ASSERT_IMPL(a_flag_far, clk, arst_n,
		result_valid && distance_q8 > irdl_pkg::OUT_W'(32512), out_of_range)

endmodule

bind ir_distance_linearizer_core irdl_checker u_irdl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.distance_q8  (distance_q8),
	.out_of_range (out_of_range)
);
